@@ rtl/bti_pkg.sv @@
// Shared constants, types and state codes of the breakpoint table interpolator.
package bti_pkg;

	// Table geometry
	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);

	// Field widths
	localparam int DATA_W      = 32;
	localparam int ENTRY_IDX_W = 6;
	localparam int ENTRIES_W   = 7;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 7;
	localparam int CLAMP_W     = (IDX_W + 1 > ENTRIES_W) ? IDX_W + 1 : ENTRIES_W;
	localparam int PROD_W      = 2 * DATA_W;
	localparam int STEP_W      = $clog2(DATA_W);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_INTERP_MODE    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE = CFG_IDX_W'(1);

	// Item functions
	localparam logic FUNC_LOAD   = 1'b0;
	localparam logic FUNC_LOOKUP = 1'b1;

	// Interpolation modes
	localparam logic MODE_STAIR  = 1'b0;
	localparam logic MODE_LINEAR = 1'b1;

	// One table entry as stored in the memory
	typedef struct packed {
		logic [DATA_W-1:0] x;
		logic [DATA_W-1:0] y;
	} bp_entry_t;

	// Request to the multiply and divide unit
	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] xd;
		logic [DATA_W-1:0] mag;
		logic [DATA_W-1:0] dx;
	} div_req_t;

	// Response of the multiply and divide unit
	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] quot;
	} div_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIRST,
		ST_LAST,
		ST_SCAN,
		ST_DIV,
		ST_DONE
	} lut_state_t;

	typedef enum logic [1:0] {
		DV_IDLE,
		DV_MUL,
		DV_RUN
	} div_state_t;

endpackage

@@ rtl/bti_if.sv @@
// Valid/ready channel interfaces for input items and result items.
interface bti_item_if import bti_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic                   func;
	logic [ENTRY_IDX_W-1:0] entry_index;
	logic [DATA_W-1:0]      x_value;
	logic [DATA_W-1:0]      y_value;

	modport source (output valid, func, entry_index, x_value, y_value, input ready);
	modport sink   (input valid, func, entry_index, x_value, y_value, output ready);
endinterface

interface bti_result_if import bti_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] y_result;

	modport source (output valid, y_result, input ready);
	modport sink   (input valid, y_result, output ready);
endinterface

@@ rtl/bti_table_ram.sv @@
// Simple dual-port synchronous RAM with a registered read.
module bti_table_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/bti_mul_div.sv @@
// Unsigned multiply followed by a 32-step restoring divide: quot = (xd * mag) / dx.
module bti_mul_div import bti_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	div_state_t        state_q, state_d;
	logic [DATA_W-1:0] a_q, b_q, dx_q, rem_q, quo_q;
	logic [STEP_W-1:0] step_q;
	logic              done_q;
	logic [PROD_W-1:0] prod;
	logic [DATA_W:0]   trial;
	logic [DATA_W:0]   diff;
	logic              fits;
	logic              last_step;

	// Product and one divide step. The quotient fits in DATA_W bits because xd < dx,
	// so the high half of the product is already below dx.
	assign prod      = PROD_W'(a_q) * PROD_W'(b_q);
	assign trial     = {rem_q, quo_q[DATA_W-1]};
	assign diff      = trial - {1'b0, dx_q};
	assign fits      = trial >= {1'b0, dx_q};
	assign last_step = step_q == STEP_W'(DATA_W - 1);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			DV_IDLE: if (req.start) state_d = DV_MUL;
			DV_MUL:  state_d = DV_RUN;
			DV_RUN:  if (last_step) state_d = DV_IDLE;
			default: state_d = DV_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == DV_RUN) && last_step;
			if (state_q == DV_MUL) begin
				step_q <= '0;
			end else if (state_q == DV_RUN) begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	// Operand, remainder and quotient registers
	always_ff @(posedge clk) begin
		case (state_q)
			DV_IDLE: begin
				if (req.start) begin
					a_q  <= req.xd;
					b_q  <= req.mag;
					dx_q <= req.dx;
				end
			end
			DV_MUL: begin
				rem_q <= prod[PROD_W-1:DATA_W];
				quo_q <= prod[DATA_W-1:0];
			end
			DV_RUN: begin
				rem_q <= fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], fits};
			end
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;

endmodule

@@ rtl/breakpoint_table_interpolator_unit.sv @@
// Top level: breakpoint table, lookup sequencer and result register.
//
//  Channel   Dir  Handshake          Beat payload
//  item      in   valid/ready        func, entry_index, x_value, y_value
//  result    out  valid/ready        y_result
//  cfg       in   cfg_we (no wait)   cfg_index, cfg_wdata
//
// A load beat writes one table entry.
// A lookup reads entry 0 and then the last entry in use, either of which can end it; else
// entries 1 onward stream from the table at one per cycle.
// Linear mode adds the multiply and the 32-step divide.
// Reset clears control state and sets the registers to linear mode, one entry in use;
// table contents stay undefined until loaded. A result waiting on result.ready holds
// the sequencer only at its final step; the next item is taken meanwhile.
module breakpoint_table_interpolator_unit import bti_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	bti_item_if.sink              item,
	bti_result_if.source          result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	lut_state_t               state_q, state_d;
	logic                     mode_q;
	logic [ENTRIES_W-1:0]     entries_q;
	logic [CLAMP_W-1:0]       ent;
	logic [IDX_W-1:0]         last_idx;
	logic [IDX_W-1:0]         scan_idx_q;
	logic [IDX_W-1:0]         rd_addr;
	logic                     rd_en;
	logic                     wr_en;
	logic                     item_acc;
	logic                     out_free;
	bp_entry_t                rdata;
	bp_entry_t                wdata;
	logic signed [DATA_W-1:0] x_q, prev_x_q, prev_y_q, last_y_q, res_q, y_out_q;
	logic signed [DATA_W-1:0] cur_x, cur_y;
	logic [DATA_W:0]          dy;
	logic                     neg_q;
	logic                     seg_hit;
	logic                     out_valid_q;
	div_req_t                 div_req;
	div_rsp_t                 div_rsp;

	assign item_acc    = item.valid && item.ready;
	assign item.ready  = state_q == ST_IDLE;
	assign out_free    = !out_valid_q || result.ready;
	assign result.valid    = out_valid_q;
	assign result.y_result = y_out_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_LINEAR;
			entries_q <= ENTRIES_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_INTERP_MODE:    mode_q    <= cfg_wdata[0];
				CFG_ENTRIES_IN_USE: entries_q <= cfg_wdata[ENTRIES_W-1:0];
				default: ;
			endcase
		end
	end

	// Index of the last entry in use, with the count clamped to 1..TABLE_DEPTH
	always_comb begin
		ent = CLAMP_W'(entries_q);
		if (ent == '0) begin
			last_idx = '0;
		end else if (ent > CLAMP_W'(TABLE_DEPTH)) begin
			last_idx = IDX_W'(TABLE_DEPTH - 1);
		end else begin
			last_idx = IDX_W'(ent - CLAMP_W'(1));
		end
	end

	// Table write from load beats
	assign wr_en   = item_acc && (item.func == FUNC_LOAD) &&
		(32'(item.entry_index) < TABLE_DEPTH);
	assign wdata.x = item.x_value;
	assign wdata.y = item.y_value;

	bti_table_ram #(
		.DEPTH(TABLE_DEPTH),
		.WIDTH($bits(bp_entry_t))
	) u_table (
		.clk  (clk),
		.we   (wr_en),
		.waddr(IDX_W'(item.entry_index)),
		.wdata(wdata),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	// Segment test and differences for the divide unit
	assign cur_x   = signed'(rdata.x);
	assign cur_y   = signed'(rdata.y);
	assign seg_hit = (x_q >= prev_x_q) && (x_q < cur_x);
	assign dy      = {cur_y[DATA_W-1], cur_y} - {prev_y_q[DATA_W-1], prev_y_q};

	assign div_req.start = (state_q == ST_SCAN) && seg_hit && (mode_q == MODE_LINEAR);
	assign div_req.xd    = DATA_W'(x_q - prev_x_q);
	assign div_req.dx    = DATA_W'(cur_x - prev_x_q);
	assign div_req.mag   = dy[DATA_W] ? DATA_W'(-dy) : dy[DATA_W-1:0];

	bti_mul_div u_mul_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// Next state and table read control
	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		rd_addr = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (item_acc && (item.func == FUNC_LOOKUP)) begin
					rd_en   = 1'b1;
					state_d = ST_FIRST;
				end
			end
			ST_FIRST: begin
				if (x_q <= cur_x) begin
					state_d = ST_DONE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = last_idx;
					state_d = ST_LAST;
				end
			end
			ST_LAST: begin
				if (x_q >= cur_x) begin
					state_d = ST_DONE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = IDX_W'(1);
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				rd_en   = 1'b1;
				rd_addr = scan_idx_q + IDX_W'(1);
				if (seg_hit) begin
					state_d = (mode_q == MODE_LINEAR) ? ST_DIV : ST_DONE;
				end else if (scan_idx_q == last_idx) begin
					state_d = ST_DONE;
				end
			end
			ST_DIV: begin
				if (div_rsp.done) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Lookup datapath: query, previous entry, last y and pending result
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (item_acc) x_q <= signed'(item.x_value);
			end
			ST_FIRST: begin
				prev_x_q <= cur_x;
				prev_y_q <= cur_y;
				res_q    <= cur_y;
			end
			ST_LAST: begin
				last_y_q   <= cur_y;
				res_q      <= cur_y;
				scan_idx_q <= IDX_W'(1);
			end
			ST_SCAN: begin
				if (seg_hit) begin
					res_q <= prev_y_q;
					neg_q <= dy[DATA_W];
				end else begin
					prev_x_q   <= cur_x;
					prev_y_q   <= cur_y;
					res_q      <= last_y_q;
					scan_idx_q <= scan_idx_q + IDX_W'(1);
				end
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					res_q <= neg_q ? prev_y_q - signed'(div_rsp.quot)
						: prev_y_q + signed'(div_rsp.quot);
				end
			end
			default: ;
		endcase
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			y_out_q <= res_q;
		end
	end

endmodule

@@ rtl/bti_checker.sv @@
// Port-level checks of the interpolator, bound to the top level.
module bti_checker import bti_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_ready,
	input logic              item_func,
	input logic              result_valid,
	input logic              result_ready,
	input logic [DATA_W-1:0] result_y
);

	// A result beat stays offered until taken.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result beat dropped before it was taken");

	// A stalled result keeps its value.
	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(result_y))
		else $error("stalled result changed");

	// A load beat never creates a result.
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && (item_func == FUNC_LOAD) && !result_valid
		|=> !result_valid)
		else $error("result appeared after a load beat");

	// A lookup needs at least one table read before its result can appear.
	a_lookup_latency: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && (item_func == FUNC_LOOKUP) && !result_valid
		|=> !result_valid)
		else $error("lookup result appeared one cycle after the beat");

	// The sequencer takes no further item while a lookup is in progress.
	a_lookup_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && (item_func == FUNC_LOOKUP) |=> !item_ready)
		else $error("item taken while a lookup was in progress");

endmodule

bind breakpoint_table_interpolator_unit bti_checker u_bti_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item.valid),
	.item_ready  (item.ready),
	.item_func   (item.func),
	.result_valid(result.valid),
	.result_ready(result.ready),
	.result_y    (result.y_result)
);

@@ bench/tb_top.sv @@
// Testbench for the breakpoint table interpolator: directed and random beats against a local model.
`timescale 1ns / 1ps

module tb_top;
	import bti_pkg::*;

	localparam int SETTLE_CYCLES  = 120;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int ITEM_TARGET    = 1100;
	localparam int QUIET_TAIL     = 150;

	localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fff_ffff;

	typedef enum logic {
		ROW_ITEM,
		ROW_CFG
	} row_kind_t;

	// One row of the directed table: an item beat or a register write.
	typedef struct {
		row_kind_t                kind;
		logic                     func;
		logic [ENTRY_IDX_W-1:0]   idx;
		logic signed [DATA_W-1:0] xv;
		logic signed [DATA_W-1:0] yv;
		bit                       typed;
		logic signed [DATA_W-1:0] want;
		logic [CFG_IDX_W-1:0]     reg_idx;
		logic [CFG_DATA_W-1:0]    reg_val;
	} plan_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	bti_item_if   item_ch ();
	bti_result_if res_ch ();

	// Local copy of the table and registers, updated as beats are accepted.
	logic signed [DATA_W-1:0] bp_x [TABLE_DEPTH];
	logic signed [DATA_W-1:0] bp_y [TABLE_DEPTH];
	logic                     cur_mode;
	logic [CFG_DATA_W-1:0]    cur_entries;

	logic signed [DATA_W-1:0] y_due [$];
	plan_row_t                plan [$];
	int                       y_errors;
	int                       items_sent;
	int                       stall_cycles;
	bit                       idle_en;

	breakpoint_table_interpolator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #4 clk = ~clk;

	// Exact linear interpolation inside one segment, with the offset from y0 truncated toward zero.
	function automatic logic signed [DATA_W-1:0] lerp_y(longint xq, longint x0, longint x1,
			longint y0, longint y1);
		longint unsigned span;
		longint unsigned offs;
		longint unsigned mag;
		longint unsigned quo;
		longint          dy;
		span = x1 - x0;
		offs = xq - x0;
		dy   = y1 - y0;
		mag  = (dy < 0) ? -dy : dy;
		quo  = (offs * mag) / span;
		if (dy < 0)
			return DATA_W'(y0 - longint'(quo));
		return DATA_W'(y0 + longint'(quo));
	endfunction

	// Expected y for a query x under the current table and registers.
	function automatic logic signed [DATA_W-1:0] interp_y(logic signed [DATA_W-1:0] qx);
		int n;
		int last;
		n = int'(cur_entries);
		if (n < 1)
			n = 1;
		if (n > TABLE_DEPTH)
			n = TABLE_DEPTH;
		last = n - 1;
		if (qx <= bp_x[0])
			return bp_y[0];
		if (qx >= bp_x[last])
			return bp_y[last];
		for (int i = 1; i < n; i++) begin
			if (qx >= bp_x[i-1] && qx < bp_x[i]) begin
				if (cur_mode == MODE_STAIR)
					return bp_y[i-1];
				return lerp_y(qx, bp_x[i-1], bp_x[i], bp_y[i-1], bp_y[i]);
			end
		end
		return bp_y[last];
	endfunction

	function automatic plan_row_t load_row(int idx, logic signed [DATA_W-1:0] xv,
			logic signed [DATA_W-1:0] yv);
		plan_row_t r;
		r      = '{kind: ROW_ITEM, func: FUNC_LOAD, default: '0};
		r.idx  = ENTRY_IDX_W'(idx);
		r.xv   = xv;
		r.yv   = yv;
		return r;
	endfunction

	function automatic plan_row_t look_row(logic signed [DATA_W-1:0] xv);
		plan_row_t r;
		r    = '{kind: ROW_ITEM, func: FUNC_LOOKUP, default: '0};
		r.xv = xv;
		return r;
	endfunction

	function automatic plan_row_t check_row(logic signed [DATA_W-1:0] xv,
			logic signed [DATA_W-1:0] want);
		plan_row_t r;
		r       = look_row(xv);
		r.typed = 1'b1;
		r.want  = want;
		return r;
	endfunction

	function automatic plan_row_t cfg_row(logic [CFG_IDX_W-1:0] reg_idx,
			logic [CFG_DATA_W-1:0] reg_val);
		plan_row_t r;
		r         = '{kind: ROW_CFG, default: '0};
		r.reg_idx = reg_idx;
		r.reg_val = reg_val;
		return r;
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_y();
		case ($urandom_range(0, 5))
			0: return S32_MIN;
			1: return S32_MAX;
			2: return int'($urandom_range(0, 200)) - 100;
			default: return $urandom;
		endcase
	endfunction

	// Query x: on or next to a breakpoint, inside the table span, at the extremes, or anywhere.
	function automatic logic signed [DATA_W-1:0] pick_query(int n_eff);
		int     k;
		longint lo;
		longint hi;
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				k = $urandom_range(0, n_eff - 1);
				return bp_x[k] + int'($urandom_range(0, 2)) - 1;
			end
			3, 4, 5: begin
				lo = bp_x[0];
				hi = bp_x[n_eff-1];
				if (hi > lo)
					return DATA_W'(lo + longint'($urandom) % (hi - lo));
				return $urandom;
			end
			6: return S32_MIN;
			7: return S32_MAX;
			default: return $urandom;
		endcase
	endfunction

	// Send one item beat; on acceptance update the table copy or queue the expected y.
	task automatic send_item(logic func, logic [ENTRY_IDX_W-1:0] idx,
			logic signed [DATA_W-1:0] xv, logic signed [DATA_W-1:0] yv,
			bit typed, logic signed [DATA_W-1:0] want);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		item_ch.valid       <= 1'b1;
		item_ch.func        <= func;
		item_ch.entry_index <= idx;
		item_ch.x_value     <= xv;
		item_ch.y_value     <= yv;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		if (func == FUNC_LOAD) begin
			bp_x[idx] = xv;
			bp_y[idx] = yv;
		end else begin
			y_due.push_back(typed ? want : interp_y(xv));
		end
		items_sent++;
		@(negedge clk);
	endtask

	// Stop sending, let every pending result arrive, then give the block time to go idle.
	task automatic drain();
		item_ch.valid <= 1'b0;
		while (y_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] reg_idx, logic [CFG_DATA_W-1:0] reg_val);
		cfg_we    <= 1'b1;
		cfg_index <= reg_idx;
		cfg_wdata <= reg_val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		if (reg_idx == CFG_INTERP_MODE)
			cur_mode = reg_val[0];
		else
			cur_entries = reg_val;
	endtask

	// Load entries 0 to n_eff-1 with breakpoints of a random shape, mostly ascending.
	task automatic load_table(int n_eff);
		int xs [$];
		int base;
		int style;
		int k;
		style = $urandom_range(0, 9);
		base  = $urandom;
		for (k = 0; k < n_eff; k++) begin
			case (style)
				0, 1, 2, 3: xs.push_back($urandom);
				4, 5:       xs.push_back(base + $urandom_range(0, 5000));
				6:          xs.push_back(base + $urandom_range(0, 3));
				default: begin
					case ($urandom_range(0, 5))
						0: xs.push_back(S32_MIN);
						1: xs.push_back(S32_MIN + 1);
						2: xs.push_back(-1);
						3: xs.push_back(0);
						4: xs.push_back(1);
						default: xs.push_back(S32_MAX);
					endcase
				end
			endcase
		end
		case ($urandom_range(0, 9))
			8: xs.rsort();
			9: ;
			default: xs.sort();
		endcase
		for (k = 0; k < n_eff; k++)
			send_item(FUNC_LOAD, ENTRY_IDX_W'(k), xs[k], pick_y(), 1'b0, '0);
	endtask

	// One phase: new register settings, a fresh table, then lookups with a few reloads mixed in.
	task automatic run_phase(bit tail);
		logic                     mode;
		logic [CFG_DATA_W-1:0]    n_set;
		int                       n_eff;
		int                       k;
		logic signed [DATA_W-1:0] xv;
		mode = $urandom_range(0, 1) ? MODE_LINEAR : MODE_STAIR;
		case ($urandom_range(0, 19))
			0:       n_set = CFG_DATA_W'(0);
			1:       n_set = CFG_DATA_W'(127);
			2:       n_set = CFG_DATA_W'(TABLE_DEPTH);
			3:       n_set = CFG_DATA_W'($urandom_range(TABLE_DEPTH + 1, 126));
			4:       n_set = CFG_DATA_W'(1);
			5:       n_set = CFG_DATA_W'(2);
			6:       n_set = CFG_DATA_W'($urandom_range(13, TABLE_DEPTH - 1));
			default: n_set = CFG_DATA_W'($urandom_range(2, 12));
		endcase
		n_eff = (n_set < 1) ? 1 : (n_set > TABLE_DEPTH) ? TABLE_DEPTH : int'(n_set);

		drain();
		if ($urandom_range(0, 1)) begin
			cfg_write(CFG_INTERP_MODE, CFG_DATA_W'(mode));
			cfg_write(CFG_ENTRIES_IN_USE, n_set);
		end else begin
			cfg_write(CFG_ENTRIES_IN_USE, n_set);
			cfg_write(CFG_INTERP_MODE, CFG_DATA_W'(mode));
		end
		idle_en = tail ? 1'b0 : ($urandom_range(0, 3) != 0);

		load_table(n_eff);
		repeat ($urandom_range(8, 30)) begin
			if ($urandom_range(0, 9) == 0) begin
				k  = $urandom_range(0, TABLE_DEPTH - 1);
				xv = $urandom_range(0, 1) ? bp_x[k] : $urandom;
				send_item(FUNC_LOAD, ENTRY_IDX_W'(k), xv, pick_y(), 1'b0, '0);
			end else begin
				send_item(FUNC_LOOKUP, ENTRY_IDX_W'($urandom), pick_query(n_eff), $urandom,
					1'b0, '0);
			end
		end
	endtask

	// Result sink: ready drops in short random bursts while idling is enabled.
	initial begin
		int hold;
		hold = 0;
		res_ch.ready <= 1'b1;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
				res_ch.ready <= 1'b0;
			end else if (idle_en && $urandom_range(0, 4) == 0) begin
				hold = $urandom_range(0, 2);
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// Compare each result beat with the oldest expected y.
	always @(posedge clk) begin
		logic signed [DATA_W-1:0] want;
		if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			if (y_due.size() == 0) begin
				$display("%0t: y_result beat with nothing pending: expected none, got %0d",
					$time, $signed(res_ch.y_result));
				y_errors++;
			end else begin
				want = y_due.pop_front();
				if (res_ch.y_result !== want) begin
					$display("%0t: y_result mismatch: expected %0d, got %0d",
						$time, want, $signed(res_ch.y_result));
					y_errors++;
				end
			end
		end
	end

	// Watchdog on cycles with no beat on any channel.
	always @(posedge clk) begin
		if ((item_ch.valid === 1'b1 && item_ch.ready === 1'b1) ||
				(res_ch.valid === 1'b1 && res_ch.ready === 1'b1) || cfg_we)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles == WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		arst_n              = 1'b0;
		item_ch.valid       = 1'b0;
		item_ch.func        = FUNC_LOAD;
		item_ch.entry_index = '0;
		item_ch.x_value     = '0;
		item_ch.y_value     = '0;
		cfg_we              = 1'b0;
		cfg_index           = CFG_INTERP_MODE;
		cfg_wdata           = '0;
		cur_mode            = MODE_LINEAR;
		cur_entries         = 1;
		y_errors            = 0;
		items_sent          = 0;
		stall_cycles        = 0;
		idle_en             = 1'b1;
		foreach (bp_x[i]) begin
			bp_x[i] = '0;
			bp_y[i] = '0;
		end

		// Directed part: one entry in use, zero entries in use, then a five-entry table
		// with a zero-width and a descending segment, in both modes.
		plan.push_back(load_row(0, S32_MIN, S32_MIN));
		plan.push_back(check_row(S32_MIN, S32_MIN));
		plan.push_back(check_row(S32_MAX, S32_MIN));
		plan.push_back(cfg_row(CFG_ENTRIES_IN_USE, 0));
		plan.push_back(check_row(12345, S32_MIN));
		plan.push_back(load_row(1, 100, S32_MAX));
		plan.push_back(load_row(2, 100, 0));
		plan.push_back(load_row(3, 50, 7));
		plan.push_back(load_row(4, S32_MAX, -5));
		plan.push_back(load_row(TABLE_DEPTH - 1, 0, 0));
		plan.push_back(cfg_row(CFG_ENTRIES_IN_USE, 5));
		plan.push_back(check_row(S32_MIN, S32_MIN));
		plan.push_back(look_row(0));
		plan.push_back(look_row(99));
		plan.push_back(look_row(100));
		plan.push_back(look_row(S32_MAX - 1));
		plan.push_back(check_row(S32_MAX, -5));
		plan.push_back(cfg_row(CFG_INTERP_MODE, CFG_DATA_W'(MODE_STAIR)));
		plan.push_back(check_row(0, S32_MIN));
		plan.push_back(check_row(100, 7));
		plan.push_back(check_row(S32_MAX, -5));

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[r]) begin
			if (plan[r].kind == ROW_CFG) begin
				drain();
				cfg_write(plan[r].reg_idx, plan[r].reg_val);
			end else begin
				send_item(plan[r].func, plan[r].idx, plan[r].xv, plan[r].yv,
					plan[r].typed, plan[r].want);
			end
		end

		// Random phases; the last stretch runs without idling on either side.
		while (items_sent < ITEM_TARGET)
			run_phase(items_sent > ITEM_TARGET - QUIET_TAIL);

		drain();
		if (y_errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
